// ===== src/inode_bitmap_allocator_macros.svh =====
//------------------------------------------------------------------------------
// Inode bitmap allocator assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
//------------------------------------------------------------------------------
`ifndef INODE_BITMAP_ALLOCATOR_MACROS_SVH
`define INODE_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTH

`define IBMA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define IBMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IBMA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`define IBMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== src/ibma_pkg.sv =====
//------------------------------------------------------------------------------
// Inode bitmap allocator package
// Sequencer states, request and status codes, file types, bit search helper.
//------------------------------------------------------------------------------
package ibma_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef logic [1:0] req_t;
    typedef logic [1:0] status_t;
    typedef logic [3:0] ftype_t;

    localparam req_t REQ_ALLOC   = 2'd0;
    localparam req_t REQ_MARK    = 2'd1;
    localparam req_t REQ_RELEASE = 2'd2;
    localparam req_t REQ_QUERY   = 2'd3;

    localparam status_t STAT_OK      = 2'd0;
    localparam status_t STAT_BADTYPE = 2'd1;
    localparam status_t STAT_FULL    = 2'd2;
    localparam status_t STAT_RANGE   = 2'd3;

    localparam ftype_t FT_REGULAR   = 4'd8;
    localparam ftype_t FT_DIRECTORY = 4'd4;
    localparam ftype_t FT_LINK      = 4'd10;

    localparam logic [7:0] BYTE_FULL = 8'hFF;

    function automatic logic [2:0] first_zero(input logic [7:0] octet);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!octet[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== src/ibma_ram.sv =====
//------------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
//------------------------------------------------------------------------------
module ibma_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/inode_bitmap_allocator.sv =====
//------------------------------------------------------------------------------
// Inode bitmap allocator
// Byte bitmap of inodes in use with first-free search, mark, release, query.
//------------------------------------------------------------------------------
// Usage: drive req_type, inode_number and file_type with start high; the
// request transfers at a clock edge where start is high and busy is low.
// Exactly one result transfers per request: done is high for one cycle
// with allocated_number, in_use and status valid. The receiver cannot
// stall; results must be taken in the cycle they appear.
// Bad-type allocate, out-of-range requests, reserved or unwritten queries
// answer straight from the idle state. Mark, release and written queries
// read the bitmap byte in ST_APPLY; mark and release also write it back.
// Allocate scans one bitmap byte per cycle from the reserved boundary up
// to the written extent, bounded by the single read port of the bitmap
// RAM. busy stays high until done.
// A new request may transfer in the same cycle done is high.
// Reset: after rst_n releases, the bitmap is cleared one byte per cycle,
// all INODE_CAPACITY/8 bytes (512 by default), with busy high throughout.
//------------------------------------------------------------------------------
`include "inode_bitmap_allocator_macros.svh"

module inode_bitmap_allocator #(
    parameter int INODE_CAPACITY  = 4096,
    parameter int RESERVED_INODES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [11:0] inode_number,
    input  logic [3:0]  file_type,
    output logic        done,
    output logic [12:0] allocated_number,
    output logic        in_use,
    output logic [1:0]  status
);

    localparam int MAP_BYTES = INODE_CAPACITY / 8;
    localparam int AW        = $clog2(MAP_BYTES);
    localparam int EW        = $clog2(MAP_BYTES + 1);
    localparam int SCAN_BASE = RESERVED_INODES / 8;
    localparam int PW        = $clog2(((MAP_BYTES > SCAN_BASE) ? MAP_BYTES : SCAN_BASE) + 1);
    localparam int FW        = $clog2(((INODE_CAPACITY > RESERVED_INODES) ?
                                       INODE_CAPACITY : RESERVED_INODES) + 1);

    ibma_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [EW-1:0]     extent_reg, extent_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     chk_pos_reg, chk_pos_next;
    logic              chk_valid_reg, chk_valid_next;
    ibma_pkg::req_t    req_reg, req_next;
    logic [11:0]       num_reg, num_next;
    logic              done_reg, done_next;
    logic [12:0]       alloc_reg, alloc_next;
    logic              in_use_reg, in_use_next;
    ibma_pkg::status_t status_reg, status_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic              in_range;
    logic              type_ok;
    logic [7:0]        bit_mask;
    logic [FW-1:0]     fallback;

    ibma_ram #(
        .WIDTH(8),
        .DEPTH(MAP_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_range = 32'(inode_number) < INODE_CAPACITY;
    assign type_ok  = (file_type == ibma_pkg::FT_REGULAR) ||
                      (file_type == ibma_pkg::FT_DIRECTORY) ||
                      (file_type == ibma_pkg::FT_LINK);
    assign bit_mask = 8'h01 << num_reg[2:0];

    always_comb
    begin
        fallback = FW'({extent_reg, 3'b000});
        if (32'(fallback) < RESERVED_INODES) begin
            fallback = FW'(RESERVED_INODES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ibma_pkg::ST_CLEAR;
            clr_reg       <= '0;
            extent_reg    <= '0;
            chk_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            extent_reg    <= extent_next;
            chk_valid_reg <= chk_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        chk_pos_reg <= chk_pos_next;
        req_reg     <= req_next;
        num_reg     <= num_next;
        alloc_reg   <= alloc_next;
        in_use_reg  <= in_use_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        extent_next    = extent_reg;
        pos_next       = pos_reg;
        chk_pos_next   = chk_pos_reg;
        chk_valid_next = chk_valid_reg;
        req_next       = req_reg;
        num_next       = num_reg;
        done_next      = 1'b0;
        alloc_next     = alloc_reg;
        in_use_next    = in_use_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(num_reg[11:3]);
        ram_wdata      = 8'h00;
        ram_raddr      = AW'(inode_number[11:3]);

        case (state_reg)
            ibma_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MAP_BYTES - 1)) begin
                    state_next = ibma_pkg::ST_IDLE;
                end
            end

            ibma_pkg::ST_IDLE: begin
                if (start) begin
                    req_next    = req_type;
                    num_next    = inode_number;
                    alloc_next  = '0;
                    in_use_next = 1'b0;
                    status_next = ibma_pkg::STAT_OK;
                    case (req_type)
                        ibma_pkg::REQ_ALLOC: begin
                            if (type_ok) begin
                                pos_next       = PW'(SCAN_BASE);
                                chk_valid_next = 1'b0;
                                state_next     = ibma_pkg::ST_SCAN;
                            end else begin
                                status_next = ibma_pkg::STAT_BADTYPE;
                                done_next   = 1'b1;
                            end
                        end
                        ibma_pkg::REQ_MARK, ibma_pkg::REQ_RELEASE: begin
                            if (in_range) begin
                                state_next = ibma_pkg::ST_APPLY;
                            end else begin
                                status_next = ibma_pkg::STAT_RANGE;
                                done_next   = 1'b1;
                            end
                        end
                        ibma_pkg::REQ_QUERY: begin
                            if (32'(inode_number) < RESERVED_INODES) begin
                                in_use_next = 1'b1;
                                done_next   = 1'b1;
                            end else if (!in_range) begin
                                status_next = ibma_pkg::STAT_RANGE;
                                done_next   = 1'b1;
                            end else if (EW'(inode_number[11:3]) < extent_reg) begin
                                state_next = ibma_pkg::ST_APPLY;
                            end else begin
                                done_next = 1'b1;
                            end
                        end
                        default: begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ibma_pkg::ST_SCAN: begin
                ram_raddr = pos_reg[AW-1:0];
                if (chk_valid_reg && (ram_rdata != ibma_pkg::BYTE_FULL)) begin
                    alloc_next     = 13'({chk_pos_reg, ibma_pkg::first_zero(ram_rdata)});
                    chk_valid_next = 1'b0;
                    done_next      = 1'b1;
                    state_next     = ibma_pkg::ST_IDLE;
                end else if (pos_reg < PW'(extent_reg)) begin
                    chk_pos_next   = pos_reg;
                    chk_valid_next = 1'b1;
                    pos_next       = pos_reg + PW'(1);
                end else begin
                    alloc_next     = 13'(fallback);
                    status_next    = (32'(fallback) >= INODE_CAPACITY) ?
                                     ibma_pkg::STAT_FULL : ibma_pkg::STAT_OK;
                    chk_valid_next = 1'b0;
                    done_next      = 1'b1;
                    state_next     = ibma_pkg::ST_IDLE;
                end
            end

            ibma_pkg::ST_APPLY: begin
                done_next  = 1'b1;
                state_next = ibma_pkg::ST_IDLE;
                if (req_reg == ibma_pkg::REQ_QUERY) begin
                    in_use_next = ram_rdata[num_reg[2:0]];
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = (req_reg == ibma_pkg::REQ_MARK) ?
                                (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
                    if (EW'(num_reg[11:3]) >= extent_reg) begin
                        extent_next = EW'(num_reg[11:3]) + EW'(1);
                    end
                end
            end

            default: begin
                state_next = ibma_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy             = (state_reg != ibma_pkg::ST_IDLE);
    assign done             = done_reg;
    assign allocated_number = alloc_reg;
    assign in_use           = in_use_reg;
    assign status           = status_reg;

    `IBMA_ASSERT_NEXT(a_extent_grows, clk, rst_n, 1'b1, extent_reg >= $past(extent_reg), "extent shrank")
    `IBMA_ASSERT_IMPL(a_we_state, clk, rst_n, ram_we, (state_reg == ibma_pkg::ST_CLEAR) || (state_reg == ibma_pkg::ST_APPLY), "bitmap write outside clear or apply")
    `IBMA_ASSERT_IMPL(a_used_ok, clk, rst_n, done_reg && in_use_reg, status_reg == ibma_pkg::STAT_OK, "in-use answer with bad status")
    `IBMA_ASSERT_IMPL(a_done_src, clk, rst_n, done_reg, $past(state_reg) != ibma_pkg::ST_CLEAR, "result during bitmap clear")

endmodule

// ===== tb/tb_inode_bitmap_allocator.sv =====
//------------------------------------------------------------------------------
// Inode bitmap allocator testbench
// Sends allocate, mark, release and query requests through the start/busy
// handshake and checks every done strobe against a scoreboard that keeps its
// own copy of the usage bitmap and the written extent. Covers small and large
// extents, all file types, reserved numbers and a long run of marked bytes.
//------------------------------------------------------------------------------
module tb_inode_bitmap_allocator;

    localparam int CAP         = 4096;
    localparam int RESV        = 16;
    localparam int MAP_OCTETS  = CAP / 8;
    localparam int MAX_GAP     = 24;
    localparam int ITEM_BOUND  = 2000;
    localparam int SCAN_CYCLES = MAP_OCTETS + 4;
    localparam int FILL_COUNT  = 480;
    localparam int LIMIT       = 4 * (11 + MAP_OCTETS +
                                      ITEM_BOUND * (MAX_GAP + SCAN_CYCLES + 1));

    typedef struct {
        logic [12:0]       number;
        logic              used;
        ibma_pkg::status_t st;
    } answer_t;

    class alloc_scoreboard;
        logic [7:0]  usage_map [MAP_OCTETS];
        int unsigned extent;
        answer_t     awaited [$];
        int          errors;
        int          checked;
        int          n_alloc;
        int          n_full;
        int          n_badtype;
        int          n_mark;
        int          n_release;
        int          n_query;

        function new();
            foreach (usage_map[i])
            begin
                usage_map[i] = 8'h00;
            end
            extent = 0;
        endfunction

        function int noted();
            return n_alloc + n_mark + n_release + n_query;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function answer_t note(ibma_pkg::req_t req, logic [11:0] num, ibma_pkg::ftype_t ft);
            answer_t     a;
            int unsigned off;
            int unsigned pos;
            int unsigned fallback;
            int          b;
            bit          found;
            logic [7:0]  mask;
            a.number = '0;
            a.used   = 1'b0;
            a.st     = ibma_pkg::STAT_OK;
            off      = int'(num) >> 3;
            mask     = 8'h01 << num[2:0];
            case (req)
                ibma_pkg::REQ_ALLOC:
                begin
                    n_alloc++;
                    if (ft != ibma_pkg::FT_REGULAR && ft != ibma_pkg::FT_DIRECTORY &&
                        ft != ibma_pkg::FT_LINK)
                    begin
                        a.st = ibma_pkg::STAT_BADTYPE;
                        n_badtype++;
                    end
                    else
                    begin
                        found = 1'b0;
                        pos   = RESV / 8;
                        while (!found && pos < extent)
                        begin
                            if (usage_map[pos] != ibma_pkg::BYTE_FULL)
                            begin
                                for (b = 0; b < 8; b++)
                                begin
                                    if (!found && !usage_map[pos][b])
                                    begin
                                        found    = 1'b1;
                                        a.number = 13'(pos * 8 + b);
                                    end
                                end
                            end
                            if (!found)
                                pos++;
                        end
                        if (!found)
                        begin
                            fallback = extent * 8;
                            if (fallback < RESV)
                                fallback = RESV;
                            a.number = 13'(fallback);
                            if (fallback >= CAP)
                            begin
                                a.st = ibma_pkg::STAT_FULL;
                                n_full++;
                            end
                        end
                    end
                end
                ibma_pkg::REQ_MARK, ibma_pkg::REQ_RELEASE:
                begin
                    if (req == ibma_pkg::REQ_MARK)
                        n_mark++;
                    else
                        n_release++;
                    if (num >= CAP || off >= MAP_OCTETS)
                        a.st = ibma_pkg::STAT_RANGE;
                    else
                    begin
                        if (req == ibma_pkg::REQ_MARK)
                            usage_map[off] = usage_map[off] | mask;
                        else
                            usage_map[off] = usage_map[off] & ~mask;
                        if (off + 1 > extent)
                            extent = off + 1;
                    end
                end
                default:
                begin
                    n_query++;
                    if (num < RESV)
                        a.used = 1'b1;
                    else if (num >= CAP || off >= MAP_OCTETS)
                        a.st = ibma_pkg::STAT_RANGE;
                    else if (off < extent)
                        a.used = |(usage_map[off] & mask);
                end
            endcase
            awaited.push_back(a);
            return a;
        endfunction

        function void check(logic [12:0] number, logic used, ibma_pkg::status_t st);
            answer_t a;
            checked++;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display({"result %0d arrived with nothing outstanding: ",
                              "number %0d in_use %0b status %0d"},
                             checked, number, used, st);
            end
            else
            begin
                a = awaited.pop_front();
                if (number !== a.number || used !== a.used || st !== a.st)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"result %0d mismatch: number exp %0d got %0d, ",
                                  "in_use exp %0b got %0b, status exp %0d got %0d"},
                                 checked, a.number, number, a.used, used, a.st, st);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  req_type;
    logic [11:0] inode_number;
    logic [3:0]  file_type;
    logic        done;
    logic [12:0] allocated_number;
    logic        in_use;
    logic [1:0]  status;

    alloc_scoreboard sb = new();
    bit              quiet;
    int              cycle_count;

    inode_bitmap_allocator #(
        .INODE_CAPACITY (CAP),
        .RESERVED_INODES(RESV)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .inode_number    (inode_number),
        .file_type       (file_type),
        .done            (done),
        .allocated_number(allocated_number),
        .in_use          (in_use),
        .status          (status)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, sb.pending());
            $display("tb_inode_bitmap_allocator: done, errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check(allocated_number, in_use, status);
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, MAX_GAP);
    endfunction

    function automatic ibma_pkg::ftype_t good_type();
        case ($urandom_range(0, 2))
            0:       return ibma_pkg::FT_REGULAR;
            1:       return ibma_pkg::FT_DIRECTORY;
            default: return ibma_pkg::FT_LINK;
        endcase
    endfunction

    // hold the request until the transfer, then idle for a random gap
    task automatic issue(ibma_pkg::req_t req, logic [11:0] num, ibma_pkg::ftype_t ft,
                         output answer_t ans);
        int gap;
        start        <= 1'b1;
        req_type     <= req;
        inode_number <= num;
        file_type    <= ft;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ans = sb.note(req, num, ft);
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_step(int win);
        answer_t     ans;
        int          pick;
        logic [11:0] n;
        pick = $urandom_range(0, 99);
        n    = 12'($urandom_range(0, win - 1));
        if (pick < 30)
        begin
            issue(ibma_pkg::REQ_ALLOC, 12'($urandom), good_type(), ans);
            if (ans.st == ibma_pkg::STAT_OK && ans.number < CAP)
                issue(ibma_pkg::REQ_MARK, ans.number[11:0], 4'($urandom), ans);
        end
        else if (pick < 45)
            issue(ibma_pkg::REQ_RELEASE, n, 4'($urandom), ans);
        else if (pick < 58)
            issue(ibma_pkg::REQ_MARK, n, 4'($urandom), ans);
        else if (pick < 70)
            issue(ibma_pkg::REQ_QUERY, n, 4'($urandom), ans);
        else if (pick < 78)
            issue(ibma_pkg::REQ_QUERY, 12'($urandom), 4'($urandom), ans);
        else if (pick < 90)
            issue(ibma_pkg::REQ_ALLOC, 12'($urandom), 4'($urandom), ans);
        else
            issue(ibma_pkg::req_t'($urandom), n, 4'($urandom), ans);
    endtask

    task automatic random_phase(int win, int count);
        int target;
        target = sb.noted() + count;
        while (sb.noted() < target)
        begin
            if (sb.noted() % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            random_step(win);
        end
    endtask

    initial
    begin
        answer_t ans;
        int      k;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req_type     <= ibma_pkg::REQ_ALLOC;
        inode_number <= '0;
        file_type    <= '0;
        quiet        = 1'b0;
        cycle_count  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        issue(ibma_pkg::REQ_ALLOC, 12'hFFF, ibma_pkg::FT_REGULAR, ans);
        issue(ibma_pkg::REQ_ALLOC, 12'h000, 4'd0, ans);
        issue(ibma_pkg::REQ_ALLOC, 12'h000, 4'd15, ans);
        issue(ibma_pkg::REQ_ALLOC, 12'h000, 4'd9, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd0, 4'd0, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd15, 4'd15, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd16, 4'd0, ans);
        issue(ibma_pkg::REQ_QUERY, 12'hFFF, 4'd0, ans);
        issue(ibma_pkg::REQ_MARK, 12'd7, 4'd0, ans);
        issue(ibma_pkg::REQ_ALLOC, 12'd0, ibma_pkg::FT_DIRECTORY, ans);
        issue(ibma_pkg::REQ_RELEASE, 12'd7, 4'd0, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd7, 4'd0, ans);
        issue(ibma_pkg::REQ_MARK, 12'd16, 4'd0, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd16, 4'd0, ans);
        issue(ibma_pkg::REQ_ALLOC, 12'd0, ibma_pkg::FT_LINK, ans);
        issue(ibma_pkg::REQ_MARK, 12'd23, 4'd0, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd22, 4'd0, ans);
        issue(ibma_pkg::REQ_RELEASE, 12'd16, 4'd0, ans);
        issue(ibma_pkg::REQ_ALLOC, 12'd0, ibma_pkg::FT_REGULAR, ans);
        issue(ibma_pkg::REQ_QUERY, 12'd23, 4'd0, ans);

        random_phase(64, 250);
        random_phase(256, 250);
        random_phase(1024, 250);
        random_phase(CAP, 250);

        quiet = 1'b0;
        for (k = RESV; k < RESV + FILL_COUNT; k++)
            issue(ibma_pkg::REQ_MARK, 12'(k), 4'($urandom), ans);
        issue(ibma_pkg::REQ_MARK, 12'hFFF, 4'($urandom), ans);
        repeat (3) issue(ibma_pkg::REQ_ALLOC, 12'($urandom), good_type(), ans);
        issue(ibma_pkg::REQ_QUERY, 12'hFFF, 4'd0, ans);
        random_phase(CAP, 250);

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display({"covered %0d requests: %0d allocate (%0d full, %0d bad type), ",
                  "%0d mark, %0d release, %0d query"},
                 sb.noted(), sb.n_alloc, sb.n_full, sb.n_badtype,
                 sb.n_mark, sb.n_release, sb.n_query);
        $display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("tb_inode_bitmap_allocator: done, clean");
        else
            $display("tb_inode_bitmap_allocator: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ibma_pkg.sv
src/ibma_ram.sv
src/inode_bitmap_allocator.sv
tb/tb_inode_bitmap_allocator.sv
